[rtl/ecd_pkg.sv]
// Eye closure detector: shared constants, register codes, FSM states and control struct.
// No dependencies; every other file of the block imports this package.
package ecd_pkg;

    localparam int ECD_COORD_BITS      = 12;
    localparam int ECD_RATIO_FRAC_BITS = 14;
    localparam int ECD_RUN_COUNT_BITS  = 8;

    // distances carry this many fraction bits (radicand scaled by 2**(2*frac))
    localparam int ECD_DIST_FRAC = 8;

    localparam int ECD_RATIO_W = 16;
    localparam logic [ECD_RATIO_W-1:0] ECD_RATIO_MAX = '1;

    localparam int ECD_THRESH_W = 16;
    localparam int ECD_FRAMES_W = 8;
    localparam logic [ECD_THRESH_W-1:0] ECD_THRESH_RESET = 16'd4096;
    localparam logic [ECD_FRAMES_W-1:0] ECD_FRAMES_RESET = 8'd3;

    localparam int ECD_CFG_IDX_W  = 4;
    localparam int ECD_CFG_DATA_W = 16;

    typedef enum logic [ECD_CFG_IDX_W-1:0] {
        REG_EAR_THRESHOLD        = 4'd0,
        REG_CLOSED_FRAMES_NEEDED = 4'd1
    } ecd_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_RATIO_LOAD,
        ST_DIVIDE,
        ST_OUTPUT
    } ecd_state_t;

    // control from the sequencer to every distance unit
    typedef struct packed {
        logic load;
        logic sq_step;
        logic sq_last;
        logic rt_step;
    } ecd_dist_ctl_t;

endpackage

[rtl/ecd_if.sv]
// Eye closure detector: valid/ready channel interfaces for frames, results and configuration.
// Depends on ecd_pkg for default widths.
interface ecd_frame_if import ecd_pkg::*; #(
    parameter int COORD_BITS = ECD_COORD_BITS
) ();
    logic                    valid;
    logic                    ready;
    logic [2*COORD_BITS-1:0] left_eye_p1;
    logic [2*COORD_BITS-1:0] left_eye_p2;
    logic [2*COORD_BITS-1:0] left_eye_p3;
    logic [2*COORD_BITS-1:0] left_eye_p4;
    logic [2*COORD_BITS-1:0] left_eye_p5;
    logic [2*COORD_BITS-1:0] left_eye_p6;
    logic [2*COORD_BITS-1:0] right_eye_p1;
    logic [2*COORD_BITS-1:0] right_eye_p2;
    logic [2*COORD_BITS-1:0] right_eye_p3;
    logic [2*COORD_BITS-1:0] right_eye_p4;
    logic [2*COORD_BITS-1:0] right_eye_p5;
    logic [2*COORD_BITS-1:0] right_eye_p6;

    modport source (
        output valid, left_eye_p1, left_eye_p2, left_eye_p3, left_eye_p4, left_eye_p5,
               left_eye_p6, right_eye_p1, right_eye_p2, right_eye_p3, right_eye_p4,
               right_eye_p5, right_eye_p6,
        input  ready
    );
    modport sink (
        input  valid, left_eye_p1, left_eye_p2, left_eye_p3, left_eye_p4, left_eye_p5,
               left_eye_p6, right_eye_p1, right_eye_p2, right_eye_p3, right_eye_p4,
               right_eye_p5, right_eye_p6,
        output ready
    );
endinterface

interface ecd_result_if import ecd_pkg::*; #(
    parameter int RUN_COUNT_BITS = ECD_RUN_COUNT_BITS
) ();
    logic                      valid;
    logic                      ready;
    logic                      closed_flag;
    logic [ECD_RATIO_W-1:0]    ear_average;
    logic [RUN_COUNT_BITS-1:0] closed_run;

    modport source (output valid, closed_flag, ear_average, closed_run, input ready);
    modport sink   (input  valid, closed_flag, ear_average, closed_run, output ready);
endinterface

interface ecd_cfg_if import ecd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [ECD_CFG_IDX_W-1:0]  index;
    logic [ECD_CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input  valid, index, data, output ready);
endinterface

[rtl/ecd_dist.sv]
// Eye closure detector: bit-serial Euclidean distance unit, shift-add square then digit-by-digit root.
// Depends on ecd_pkg; sequenced by eye_closure_detector through ecd_dist_ctl_t.
module ecd_dist import ecd_pkg::*; #(
    parameter int COORD_BITS = ECD_COORD_BITS
) (
    input  logic                                  clk,
    input  ecd_dist_ctl_t                         ctl,
    input  logic [2*COORD_BITS-1:0]               p,
    input  logic [2*COORD_BITS-1:0]               q,
    output logic [COORD_BITS+ECD_DIST_FRAC:0]     span
);

    localparam int SQ_W   = 2*COORD_BITS + 1;
    localparam int ROOT_W = COORD_BITS + ECD_DIST_FRAC + 1;
    localparam int RAD_W  = 2*ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0]      mag_x, mag_y;

    logic [COORD_BITS-1:0] mplx_reg, mplx_next, mply_reg, mply_next;
    logic [SQ_W-2:0]       mcx_reg, mcx_next, mcy_reg, mcy_next;
    logic [SQ_W-1:0]       acc_reg, acc_next;
    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic [REM_W-1:0]      rem_reg, rem_next, rem_sh, trial;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic                  go;

    always_comb
    begin
        dx = $signed({p[2*COORD_BITS-1], p[2*COORD_BITS-1:COORD_BITS]})
           - $signed({q[2*COORD_BITS-1], q[2*COORD_BITS-1:COORD_BITS]});
        dy = $signed({p[COORD_BITS-1], p[COORD_BITS-1:0]})
           - $signed({q[COORD_BITS-1], q[COORD_BITS-1:0]});
        mag_x = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        mag_y = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);

        // one multiplier bit of each square per step
        acc_next = acc_reg + (mplx_reg[0] ? SQ_W'(mcx_reg) : '0)
                           + (mply_reg[0] ? SQ_W'(mcy_reg) : '0);

        // bring down two radicand bits, try root*4+1
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        go     = rem_sh >= trial;

        mplx_next = mplx_reg;
        mply_next = mply_reg;
        mcx_next  = mcx_reg;
        mcy_next  = mcy_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;

        if (ctl.load)
        begin
            mplx_next = mag_x;
            mply_next = mag_y;
            mcx_next  = (SQ_W-1)'(mag_x);
            mcy_next  = (SQ_W-1)'(mag_y);
        end
        else if (ctl.sq_step)
        begin
            mplx_next = mplx_reg >> 1;
            mply_next = mply_reg >> 1;
            mcx_next  = mcx_reg << 1;
            mcy_next  = mcy_reg << 1;
        end

        if (ctl.sq_step && ctl.sq_last)
        begin
            rad_next  = {1'b0, acc_next, {(2*ECD_DIST_FRAC){1'b0}}};
            rem_next  = '0;
            root_next = '0;
        end
        else if (ctl.rt_step)
        begin
            rad_next  = rad_reg << 2;
            rem_next  = go ? REM_W'(rem_sh - trial) : rem_sh;
            root_next = {root_reg[ROOT_W-2:0], go};
        end
    end

    always_ff @(posedge clk)
    begin
        mplx_reg <= mplx_next;
        mply_reg <= mply_next;
        mcx_reg  <= mcx_next;
        mcy_reg  <= mcy_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        if (ctl.load)
            acc_reg <= '0;
        else if (ctl.sq_step)
            acc_reg <= acc_next;
    end

    assign span = root_reg;

endmodule

[rtl/eye_closure_detector.sv]
// Eye closure detector top level: sequencer, six distance units, two serial dividers, run counter.
// Depends on ecd_pkg, ecd_if (channel interfaces) and ecd_dist.
//
//   channel     dir   handshake      word
//   frame_in    in    valid/ready    twelve packed landmarks, x in high half, y in low half
//   result_out  out   valid/ready    closed_flag, ear_average, closed_run
//   cfg         in    valid/ready    register index and write data (always ready)
//
// One frame at a time: a load, the squaring steps (one multiplier bit each), the root steps
// (one root bit each), a ratio setup, the divide steps (one quotient bit each) and the output
// state; the six distance units step in parallel. The output register lets the next frame be
// taken while a result waits; a finished frame stalls in the output state until result_out
// is free. Reset clears run count and output valid and loads the register defaults.
module eye_closure_detector import ecd_pkg::*; #(
    parameter int COORD_BITS      = ECD_COORD_BITS,
    parameter int RATIO_FRAC_BITS = ECD_RATIO_FRAC_BITS,
    parameter int RUN_COUNT_BITS  = ECD_RUN_COUNT_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    ecd_frame_if.sink    frame_in,
    ecd_result_if.source result_out,
    ecd_cfg_if.sink      cfg
);

    localparam int ROOT_W    = COORD_BITS + ECD_DIST_FRAC + 1;
    localparam int D_W       = ROOT_W + 1;
    localparam int NUM_W     = D_W + RATIO_FRAC_BITS;
    localparam int CMP_W     = NUM_W + ECD_RATIO_W + 1;
    localparam int CNT_W     = $clog2(ROOT_W + 1);
    localparam int RUN_CMP_W = (RUN_COUNT_BITS > ECD_FRAMES_W) ? RUN_COUNT_BITS : ECD_FRAMES_W;

    ecd_state_t state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;

    ecd_dist_ctl_t ctl;
    logic in_ready, div_load, div_step, out_load, slot_free;

    logic [2*COORD_BITS-1:0] pts [12];
    logic [ROOT_W-1:0] dist_a [2];
    logic [ROOT_W-1:0] dist_b [2];
    logic [ROOT_W-1:0] dist_c [2];

    // serial dividers, one per eye
    logic [D_W-1:0]         sum_ab [2];
    logic [D_W-1:0]         den_new [2];
    logic [NUM_W-1:0]       num [2];
    logic                   sat_new [2];
    logic [D_W:0]           div_tr [2];
    logic                   div_go [2];
    logic [D_W-1:0]         den_reg [2], den_next [2];
    logic [D_W-1:0]         rem_reg [2], rem_next [2];
    logic [ECD_RATIO_W-1:0] nlow_reg [2], nlow_next [2];
    logic [ECD_RATIO_W-1:0] quo_reg [2], quo_next [2];
    logic                   sat_reg [2], sat_next [2];
    logic                   zero_reg [2], zero_next [2];
    logic [ECD_RATIO_W-1:0] ratio [2];

    logic [ECD_RATIO_W:0]    ratio_sum;
    logic [ECD_RATIO_W-1:0]  avg;
    logic                    low;

    logic [ECD_THRESH_W-1:0]   thresh_reg, thresh_next;
    logic [ECD_FRAMES_W-1:0]   frames_reg, frames_next;
    logic [RUN_COUNT_BITS-1:0] run_reg, run_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      closed_reg;
    logic [ECD_RATIO_W-1:0]    avg_reg;
    logic [RUN_COUNT_BITS-1:0] run_out_reg;

    assign pts[0]  = frame_in.left_eye_p1;
    assign pts[1]  = frame_in.left_eye_p2;
    assign pts[2]  = frame_in.left_eye_p3;
    assign pts[3]  = frame_in.left_eye_p4;
    assign pts[4]  = frame_in.left_eye_p5;
    assign pts[5]  = frame_in.left_eye_p6;
    assign pts[6]  = frame_in.right_eye_p1;
    assign pts[7]  = frame_in.right_eye_p2;
    assign pts[8]  = frame_in.right_eye_p3;
    assign pts[9]  = frame_in.right_eye_p4;
    assign pts[10] = frame_in.right_eye_p5;
    assign pts[11] = frame_in.right_eye_p6;

    for (genvar e = 0; e < 2; e++)
    begin : g_eye
        // vertical spans p2-p6 and p3-p5, horizontal span p1-p4
        ecd_dist #(.COORD_BITS(COORD_BITS)) u_dist_a (
            .clk(clk), .ctl(ctl), .p(pts[6*e+1]), .q(pts[6*e+5]), .span(dist_a[e])
        );
        ecd_dist #(.COORD_BITS(COORD_BITS)) u_dist_b (
            .clk(clk), .ctl(ctl), .p(pts[6*e+2]), .q(pts[6*e+4]), .span(dist_b[e])
        );
        ecd_dist #(.COORD_BITS(COORD_BITS)) u_dist_c (
            .clk(clk), .ctl(ctl), .p(pts[6*e]), .q(pts[6*e+3]), .span(dist_c[e])
        );
    end

    // ---------------- sequencer ----------------
    assign slot_free = !out_valid_reg || result_out.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (frame_in.valid)
                    state_next = ST_SQUARE;
            ST_SQUARE:
                if (step_reg == CNT_W'(COORD_BITS - 1))
                    state_next = ST_ROOT;
            ST_ROOT:
                if (step_reg == CNT_W'(ROOT_W - 1))
                    state_next = ST_RATIO_LOAD;
            ST_RATIO_LOAD:
                state_next = ST_DIVIDE;
            ST_DIVIDE:
                if (step_reg == CNT_W'(ECD_RATIO_W - 1))
                    state_next = ST_OUTPUT;
            ST_OUTPUT:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
        step_next = (state_next != state_reg) ? '0 : step_reg + 1'b1;
    end

    always_comb
    begin
        in_ready    = 1'b0;
        ctl         = '0;
        div_load    = 1'b0;
        div_step    = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = frame_in.valid;
            end
            ST_SQUARE:
            begin
                ctl.sq_step = 1'b1;
                ctl.sq_last = step_reg == CNT_W'(COORD_BITS - 1);
            end
            ST_ROOT:
                ctl.rt_step = 1'b1;
            ST_RATIO_LOAD:
                div_load = 1'b1;
            ST_DIVIDE:
                div_step = 1'b1;
            ST_OUTPUT:
                out_load = slot_free;
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // ---------------- dividers ----------------
    always_comb
    begin
        for (int e = 0; e < 2; e++)
        begin
            sum_ab[e]  = D_W'(dist_a[e]) + D_W'(dist_b[e]);
            den_new[e] = {dist_c[e], 1'b0};
            num[e]     = {sum_ab[e], {RATIO_FRAC_BITS{1'b0}}};
            // quotient of 2**16 or more saturates; a zero span lands here too
            sat_new[e] = CMP_W'(num[e]) >= (CMP_W'(den_new[e]) << ECD_RATIO_W);
            div_tr[e]  = {rem_reg[e], nlow_reg[e][ECD_RATIO_W-1]};
            div_go[e]  = div_tr[e] >= {1'b0, den_reg[e]};

            den_next[e]  = den_reg[e];
            rem_next[e]  = rem_reg[e];
            nlow_next[e] = nlow_reg[e];
            quo_next[e]  = quo_reg[e];
            sat_next[e]  = sat_reg[e];
            zero_next[e] = zero_reg[e];
            if (div_load)
            begin
                den_next[e]  = den_new[e];
                rem_next[e]  = D_W'(num[e] >> ECD_RATIO_W);
                nlow_next[e] = num[e][ECD_RATIO_W-1:0];
                quo_next[e]  = '0;
                sat_next[e]  = sat_new[e];
                zero_next[e] = dist_c[e] == '0;
            end
            else if (div_step)
            begin
                rem_next[e]  = div_go[e] ? D_W'(div_tr[e] - {1'b0, den_reg[e]})
                                         : D_W'(div_tr[e]);
                nlow_next[e] = nlow_reg[e] << 1;
                quo_next[e]  = {quo_reg[e][ECD_RATIO_W-2:0], div_go[e]};
            end

            ratio[e] = zero_reg[e] ? '0 : (sat_reg[e] ? ECD_RATIO_MAX : quo_reg[e]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int e = 0; e < 2; e++)
        begin
            den_reg[e]  <= den_next[e];
            rem_reg[e]  <= rem_next[e];
            nlow_reg[e] <= nlow_next[e];
            quo_reg[e]  <= quo_next[e];
            sat_reg[e]  <= sat_next[e];
            zero_reg[e] <= zero_next[e];
        end
    end

    // ---------------- run counter and output register ----------------
    always_comb
    begin
        ratio_sum = {1'b0, ratio[0]} + {1'b0, ratio[1]};
        avg       = ratio_sum[ECD_RATIO_W:1];
        low       = avg < thresh_reg;

        run_next = run_reg;
        if (out_load)
        begin
            if (!low)
                run_next = '0;
            else if (run_reg != '1)
                run_next = run_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            closed_reg  <= RUN_CMP_W'(run_next) >= RUN_CMP_W'(frames_reg);
            avg_reg     <= avg;
            run_out_reg <= run_next;
        end
    end

    assign frame_in.ready         = in_ready;
    assign result_out.valid       = out_valid_reg;
    assign result_out.closed_flag = closed_reg;
    assign result_out.ear_average = avg_reg;
    assign result_out.closed_run  = run_out_reg;

    // ---------------- configuration ----------------
    always_comb
    begin
        thresh_next = thresh_reg;
        frames_next = frames_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_EAR_THRESHOLD:        thresh_next = cfg.data[ECD_THRESH_W-1:0];
                REG_CLOSED_FRAMES_NEEDED: frames_next = cfg.data[ECD_FRAMES_W-1:0];
                default:                  thresh_next = thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= ECD_THRESH_RESET;
            frames_reg <= ECD_FRAMES_RESET;
        end
        else
        begin
            thresh_reg <= thresh_next;
            frames_reg <= frames_next;
        end
    end

    assign cfg.ready = 1'b1;

    // ---------------- assertions ----------------
    a_one_frame_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        frame_in.valid && frame_in.ready |=> !frame_in.ready)
        else $error("frame taken while another is in flight");

    a_root_complete: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RATIO_LOAD |-> $past(state_reg) == ST_ROOT
                                       && $past(step_reg) == CNT_W'(ROOT_W - 1))
        else $error("ratio setup entered before the root finished");

    a_run_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> run_reg == '0 || run_reg == $past(run_reg) + 1'b1
                     || (run_reg == $past(run_reg) && run_reg == '1))
        else $error("run count moved by other than one step");

    a_high_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && !low |=> result_out.closed_run == '0)
        else $error("run not cleared by a high ratio");

endmodule

[bench/eye_closure_detector_tb.sv]
`timescale 1ns / 100ps
// Eye closure detector testbench: landmark frames in, ratio and run verdicts checked
// against an in-bench predictor, with register changes and random idling on both channels.
// Depends on ecd_pkg, the channel interfaces of ecd_if and the eye_closure_detector top level.
module eye_closure_detector_tb;
    import ecd_pkg::*;

    localparam int PT_W          = 2*ECD_COORD_BITS;
    localparam int COORD_MAX     = (1 << (ECD_COORD_BITS-1)) - 1;
    localparam int COORD_MIN     = -COORD_MAX - 1;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 64;

    typedef logic [PT_W-1:0] eye_pts_t [6];

    typedef struct {
        eye_pts_t left;
        eye_pts_t right;
    } face_frame_t;

    typedef struct packed {
        logic                          closed_flag;
        logic [ECD_RATIO_W-1:0]        ear_average;
        logic [ECD_RUN_COUNT_BITS-1:0] closed_run;
    } eye_verdict_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ecd_frame_if  frm();
    ecd_result_if res();
    ecd_cfg_if    cfg_bus();

    eye_closure_detector u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frm),
        .result_out (res),
        .cfg        (cfg_bus)
    );

    // mirrored registers and low-ratio run
    logic [ECD_THRESH_W-1:0]       thresh_q;
    logic [ECD_FRAMES_W-1:0]       frames_needed_q;
    logic [ECD_RUN_COUNT_BITS-1:0] low_run;

    eye_verdict_t pending_verdicts[$];
    eye_verdict_t due;
    int mismatches  = 0;
    int cycle_count = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    bit lids_shut   = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int k = 21; k >= 0; k--)
        begin
            trial = r | (64'd1 << k);
            if (trial * trial <= n)
                r = trial;
        end
        return r;
    endfunction

    // Q.8 length of the segment between two packed points
    function automatic longint unsigned span_q8(logic [PT_W-1:0] p, logic [PT_W-1:0] q);
        logic signed [ECD_COORD_BITS-1:0] px, py, qx, qy;
        int dx;
        int dy;
        longint unsigned sq;
        {px, py} = p;
        {qx, qy} = q;
        dx = px - qx;
        dy = py - qy;
        sq = longint'(dx * dx) + longint'(dy * dy);
        return floor_root(sq << (2*ECD_DIST_FRAC));
    endfunction

    function automatic logic [ECD_RATIO_W-1:0] eye_ratio(eye_pts_t e);
        longint unsigned a, b, c, q;
        a = span_q8(e[1], e[5]);
        b = span_q8(e[2], e[4]);
        c = span_q8(e[0], e[3]);
        if (c == 0)
            return '0;
        q = ((a + b) << ECD_RATIO_FRAC_BITS) / (2 * c);
        return (q > ECD_RATIO_MAX) ? ECD_RATIO_MAX : q[ECD_RATIO_W-1:0];
    endfunction

    // advances the run, so call once per accepted frame and in order
    function automatic eye_verdict_t predict_verdict(face_frame_t f);
        logic [ECD_RATIO_W:0] both;
        eye_verdict_t v;
        both = eye_ratio(f.left) + eye_ratio(f.right);
        v.ear_average = both[ECD_RATIO_W:1];
        if (v.ear_average < thresh_q)
        begin
            if (low_run != '1)
                low_run++;
        end
        else
            low_run = '0;
        v.closed_run  = low_run;
        v.closed_flag = (low_run >= frames_needed_q);
        return v;
    endfunction

    function automatic logic [PT_W-1:0] pack_pt(int x, int y);
        return {x[ECD_COORD_BITS-1:0], y[ECD_COORD_BITS-1:0]};
    endfunction

    function automatic int wobble(int amp);
        return int'($urandom_range(0, 2*amp)) - amp;
    endfunction

    // eye of half-width w and half-opening h; ratio h/w before jitter
    function automatic eye_pts_t lid_eye(int cx, int cy, int w, int h, int jit);
        eye_pts_t e;
        int s;
        s = w / 3;
        e[0] = pack_pt(cx - w + wobble(jit), cy + wobble(jit));
        e[1] = pack_pt(cx - s + wobble(jit), cy - h + wobble(jit));
        e[2] = pack_pt(cx + s + wobble(jit), cy - h + wobble(jit));
        e[3] = pack_pt(cx + w + wobble(jit), cy + wobble(jit));
        e[4] = pack_pt(cx + s + wobble(jit), cy + h + wobble(jit));
        e[5] = pack_pt(cx - s + wobble(jit), cy + h + wobble(jit));
        return e;
    endfunction

    function automatic int rim_coord();
        case ($urandom_range(0, 4))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return -1;
            3:       return 0;
            default: return int'($urandom_range(0, 2*COORD_MAX + 1)) + COORD_MIN;
        endcase
    endfunction

    function automatic face_frame_t random_frame();
        face_frame_t f;
        int w, h, pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 5) == 0)
            lids_shut = !lids_shut;
        w = $urandom_range(4, 400);
        h = lids_shut ? int'($urandom_range(0, w/5)) : int'($urandom_range(w/4, w));
        f.left  = lid_eye(int'($urandom_range(0, 3000)) - 1500,
                          int'($urandom_range(0, 3000)) - 1500, w, h, 2);
        f.right = lid_eye(int'($urandom_range(0, 3000)) - 1500,
                          int'($urandom_range(0, 3000)) - 1500, w, h, 2);
        if (pick >= 75 && pick < 85)
        begin
            foreach (f.left[i])
            begin
                f.left[i]  = PT_W'($urandom);
                f.right[i] = PT_W'($urandom);
            end
        end
        else if (pick >= 85 && pick < 93)
        begin
            // collapse one eye: corners coincide
            if ($urandom_range(0, 1))
                f.left[3] = f.left[0];
            else
                f.right[3] = f.right[0];
        end
        else if (pick >= 93)
        begin
            foreach (f.left[i])
            begin
                f.left[i]  = pack_pt(rim_coord(), rim_coord());
                f.right[i] = pack_pt(rim_coord(), rim_coord());
            end
        end
        return f;
    endfunction

    task automatic put_frame(face_frame_t f, logic v);
        frm.valid        <= v;
        frm.left_eye_p1  <= f.left[0];
        frm.left_eye_p2  <= f.left[1];
        frm.left_eye_p3  <= f.left[2];
        frm.left_eye_p4  <= f.left[3];
        frm.left_eye_p5  <= f.left[4];
        frm.left_eye_p6  <= f.left[5];
        frm.right_eye_p1 <= f.right[0];
        frm.right_eye_p2 <= f.right[1];
        frm.right_eye_p3 <= f.right[2];
        frm.right_eye_p4 <= f.right[3];
        frm.right_eye_p5 <= f.right[4];
        frm.right_eye_p6 <= f.right[5];
    endtask

    // call at a rising edge; returns in the step of the accepting edge with valid still high
    task automatic send_frame(face_frame_t f);
        eye_verdict_t v;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            frm.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        put_frame(f, 1'b1);
        @(posedge clk);
        while (!frm.ready)
            @(posedge clk);
        v = predict_verdict(f);
        pending_verdicts.insert(pending_verdicts.size(), v);
    endtask

    task automatic write_reg(logic [ECD_CFG_IDX_W-1:0] idx, logic [ECD_CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            REG_EAR_THRESHOLD:        thresh_q = val[ECD_THRESH_W-1:0];
            REG_CLOSED_FRAMES_NEEDED: frames_needed_q = val[ECD_FRAMES_W-1:0];
            default: ;
        endcase
        // drop valid for a cycle so back-to-back writes stay distinct
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold until every verdict is in and the block has gone quiet
    task automatic settle();
        frm.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_frames();
        face_frame_t f;
        eye_pts_t flat, spike;
        gap_pct   = 30;
        stall_pct = 10;
        foreach (flat[i])
            flat[i] = '0;
        f.left  = flat;
        f.right = flat;
        repeat (3) send_frame(f);
        foreach (flat[i])
            flat[i] = '1;
        f.left  = flat;
        f.right = flat;
        send_frame(f);
        f.left  = lid_eye(0, 0, 30, 8, 0);
        f.right = lid_eye(100, -50, 30, 8, 0);
        send_frame(f);
        // average exactly on the default threshold, then just under it
        f.left  = lid_eye(-200, 10, 40, 10, 0);
        f.right = lid_eye(200, 10, 40, 10, 0);
        send_frame(f);
        f.left  = lid_eye(-200, 10, 41, 10, 0);
        f.right = lid_eye(200, 10, 41, 10, 0);
        send_frame(f);
        // tiny corner span against full-range lids: ratio saturates
        spike[0] = pack_pt(0, 0);
        spike[3] = pack_pt(1, 0);
        spike[1] = pack_pt(COORD_MIN, COORD_MIN);
        spike[5] = pack_pt(COORD_MAX, COORD_MAX);
        spike[2] = pack_pt(COORD_MAX, COORD_MIN);
        spike[4] = pack_pt(COORD_MIN, COORD_MAX);
        f.left  = spike;
        f.right = spike;
        send_frame(f);
        f.right = flat;
        send_frame(f);
        f.left[0] = pack_pt(COORD_MIN, COORD_MIN);
        f.left[3] = pack_pt(COORD_MAX, COORD_MAX);
        f.left[1] = pack_pt(COORD_MAX, COORD_MIN);
        f.left[5] = pack_pt(COORD_MIN, COORD_MAX);
        f.left[2] = pack_pt(COORD_MIN, 0);
        f.left[4] = pack_pt(COORD_MAX, -1);
        foreach (f.right[i])
            f.right[i] = pack_pt(COORD_MIN, COORD_MIN);
        f.right[3] = pack_pt(COORD_MAX, COORD_MAX);
        send_frame(f);
        f.left  = lid_eye(-600, 300, 300, 0, 0);
        f.right = lid_eye(600, 300, 300, 0, 0);
        repeat (3) send_frame(f);
        f.left  = lid_eye(-1500, 1500, 400, 400, 0);
        f.right = lid_eye(1500, -1500, 400, 400, 0);
        send_frame(f);
    endtask

    task automatic test_register_extremes();
        settle();
        write_reg(REG_EAR_THRESHOLD, '0);
        write_reg(REG_CLOSED_FRAMES_NEEDED, '0);
        repeat (3) send_frame(random_frame());
        settle();
        write_reg(REG_EAR_THRESHOLD, '1);
        // upper data bits are not part of the frame count
        write_reg(REG_CLOSED_FRAMES_NEEDED, 16'hFF01);
        repeat (3) send_frame(random_frame());
        settle();
        write_reg(REG_CLOSED_FRAMES_NEEDED, 16'h00FF);
        repeat (3) send_frame(random_frame());
    endtask

    task automatic test_unknown_register();
        logic [ECD_CFG_IDX_W-1:0] idx;
        settle();
        write_reg(REG_EAR_THRESHOLD, ECD_THRESH_RESET);
        write_reg(REG_CLOSED_FRAMES_NEEDED, ECD_FRAMES_RESET);
        do
            idx = ECD_CFG_IDX_W'($urandom);
        while (idx == REG_EAR_THRESHOLD || idx == REG_CLOSED_FRAMES_NEEDED);
        write_reg(idx, ECD_CFG_DATA_W'($urandom));
        repeat (4) send_frame(random_frame());
    endtask

    task automatic run_phase(int thresh, int needed, int count, int gap, int stall);
        settle();
        write_reg(REG_EAR_THRESHOLD, thresh[ECD_CFG_DATA_W-1:0]);
        write_reg(REG_CLOSED_FRAMES_NEEDED, needed[ECD_CFG_DATA_W-1:0]);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (count) send_frame(random_frame());
    endtask

    task automatic test_random_frames();
        run_phase(ECD_THRESH_RESET, ECD_FRAMES_RESET, 250, 25, 8);
        // almost every frame is low here, so the run climbs into saturation
        run_phase(16'hFFFF, 255, 300, 20, 10);
        run_phase(0, 1, 150, 30, 5);
        run_phase($urandom_range(0, 16'hFFFF), $urandom_range(1, 8), 250, 0, 0);
        run_phase(ECD_THRESH_RESET, 1, 250, 40, 0);
        run_phase($urandom_range(2000, 8000), 0, 200, 0, 15);
        run_phase($urandom_range(3000, 6000), $urandom_range(2, 255), 250, 20, 10);
        // no idling on either side to the end
        run_phase(ECD_THRESH_RESET, 2, 300, 0, 0);
    endtask

    initial
    begin : result_backpressure
        int hold;
        hold      = 0;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                res.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                hold = $urandom_range(0, 16);
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, got closed=%0b avg=%0d run=%0d",
                         $time, res.closed_flag, res.ear_average, res.closed_run);
                mismatches++;
            end
            else
            begin
                due = pending_verdicts.pop_front();
                if (res.closed_flag !== due.closed_flag)
                begin
                    $display("%0t: closed_flag: expected %0b, got %0b",
                             $time, due.closed_flag, res.closed_flag);
                    mismatches++;
                end
                if (res.ear_average !== due.ear_average)
                begin
                    $display("%0t: ear_average: expected %0d, got %0d",
                             $time, due.ear_average, res.ear_average);
                    mismatches++;
                end
                if (res.closed_run !== due.closed_run)
                begin
                    $display("%0t: closed_run: expected %0d, got %0d",
                             $time, due.closed_run, res.closed_run);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("eye_closure_detector_tb: errors");
        $finish;
    end

    initial
    begin : main_sequence
        face_frame_t blank;
        foreach (blank.left[i])
        begin
            blank.left[i]  = '0;
            blank.right[i] = '0;
        end
        put_frame(blank, 1'b0);
        cfg_bus.valid   = 1'b0;
        cfg_bus.index   = '0;
        cfg_bus.data    = '0;
        thresh_q        = ECD_THRESH_RESET;
        frames_needed_q = ECD_FRAMES_RESET;
        low_run         = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_register_extremes();
        test_unknown_register();
        test_random_frames();
        settle();
        if (mismatches == 0)
            $display("eye_closure_detector_tb: clean");
        else
            $display("eye_closure_detector_tb: errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/ecd_pkg.sv
rtl/ecd_if.sv
rtl/ecd_dist.sv
rtl/eye_closure_detector.sv
bench/eye_closure_detector_tb.sv
